### rtl/cse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

  // Beat layout of the input and output streams.
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 3;

  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgW   = 8;

  localparam logic [PosW-1:0] PairsPerPacket = 8'd128;
  localparam logic [15:0]     SupportedLen   = 16'd256;

  // Subcarrier bounds per limit mode.
  localparam logic [5:0] Limit26 = 6'd26;
  localparam logic [5:0] Limit28 = 6'd28;
  localparam logic [5:0] Limit57 = 6'd57;

  localparam logic [1:0] ModeReset = 2'd1;
  localparam logic [7:0] CapReset  = 8'd128;

  // Register indexes on the configuration port.
  localparam logic RegMode     = 1'b0;
  localparam logic RegCapacity = 1'b1;

  // One result bit per square root iteration.
  localparam int unsigned RootW = 16;
  localparam logic [3:0]  LastStep = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } cse_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } cse_cmd_t;

  typedef struct packed {
    logic keep_now;
    logic sqrt_last;
  } cse_status_t;

endpackage

`default_nettype wire

### rtl/cse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  input  cse_pkg::cse_status_t status_i,
  output cse_pkg::cse_cmd_t    cmd_o
);
  import cse_pkg::*;

  cse_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = status_i.keep_now ? ST_CALC : ST_DONE;
        end
      end
      ST_CALC: begin
        if (status_i.sqrt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready   = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.step      = 1'b0;
    cmd_o.out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      ST_CALC: cmd_o.step = 1'b1;
      ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // The output register stays full until the sink takes the beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  cse_pkg::cse_cmd_t              cmd_i,
  output cse_pkg::cse_status_t           status_o,
  input  wire [cse_pkg::InDataW-1:0]     in_data_i,
  input  wire [cse_pkg::InUserW-1:0]     in_user_i,
  output logic [cse_pkg::OutDataW-1:0]   out_data_o,
  output logic [cse_pkg::OutUserW-1:0]   out_user_o,
  output logic                           out_last_o,
  input  wire                            cfg_we_i,
  input  wire                            cfg_idx_i,
  input  wire [cse_pkg::CfgW-1:0]        cfg_data_i
);
  import cse_pkg::*;

  // Configuration.
  logic [1:0]        mode_q;
  logic [CfgW-1:0]   cap_q;

  // Packet state.
  logic [PosW-1:0]   pos_q;
  logic [CountW-1:0] cnt_q;
  logic              trunc_q, layout_q, skip_q;

  // Input fields.
  logic              start, fwi;
  logic [15:0]       len;
  logic signed [7:0] q_in, i_in;

  assign start = in_user_i[0];
  assign fwi   = in_user_i[1];
  assign len   = in_data_i[15:0];
  assign q_in  = in_data_i[23:16];
  assign i_in  = in_data_i[31:24];

  logic [PosW-1:0]   pos_eff, pos_new;
  logic [CountW-1:0] cnt_eff, cnt_new;
  logic              trunc_eff, layout_eff, skip_eff, trunc_new;
  logic              in_range, qualify, keep, last;
  logic [5:0]        idx, abs_idx, limit;
  logic signed [15:0] sq_i, sq_q;
  logic [15:0]       power;

  always_comb begin
    unique case (mode_q)
      2'd0:    limit = Limit26;
      2'd1:    limit = Limit28;
      default: limit = Limit57;
    endcase
  end

  always_comb begin
    if (start) begin
      pos_eff    = '0;
      cnt_eff    = '0;
      trunc_eff  = 1'b0;
      layout_eff = (len == SupportedLen);
      skip_eff   = fwi;
    end else begin
      pos_eff    = pos_q;
      cnt_eff    = cnt_q;
      trunc_eff  = trunc_q;
      layout_eff = layout_q;
      skip_eff   = skip_q;
    end
  end

  assign in_range = (pos_eff < PairsPerPacket);
  // The upper half of each 64-pair block carries the negative indexes.
  assign idx      = in_range ? {pos_eff[5], pos_eff[4:0]} : 6'd0;
  assign abs_idx  = idx[5] ? (~idx + 6'd1) : idx;
  assign qualify  = in_range && layout_eff && !(skip_eff && (pos_eff < 8'd2))
                    && (abs_idx != 6'd0) && (abs_idx <= limit);
  assign keep     = qualify && (cnt_eff < cap_q);
  assign trunc_new = trunc_eff || (qualify && !keep);
  assign cnt_new  = cnt_eff + CountW'(keep);
  assign pos_new  = in_range ? pos_eff + 8'd1 : pos_eff;
  assign last     = in_range && (pos_eff == PairsPerPacket - 8'd1);

  assign sq_i  = i_in * i_in;
  assign sq_q  = q_in * q_in;
  assign power = $unsigned(sq_i) + $unsigned(sq_q);

  assign status_o.keep_now = keep;

  // Work registers for the pair in flight.
  logic              kept_w, trunc_w, layout_w, last_w;
  logic [5:0]        idx_w;
  logic [7:0]        i_w, q_w;
  logic [15:0]       power_w;
  logic [CountW-1:0] cnt_w;

  // Square root iteration: two radicand bits and one root bit per cycle.
  logic [31:0]       x_q;
  logic [15:0]       rem_q;
  logic [RootW-1:0]  root_q;
  logic [3:0]        step_q;
  logic [17:0]       rem_next, trial, rem_sub;
  logic              fits;

  assign rem_next = {rem_q, x_q[31:30]};
  assign trial    = {root_q, 2'b01};
  assign fits     = (rem_next >= trial);
  assign rem_sub  = rem_next - trial;
  assign status_o.sqrt_last = (step_q == LastStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeReset;
      cap_q    <= CapReset;
      pos_q    <= '0;
      cnt_q    <= '0;
      trunc_q  <= 1'b0;
      layout_q <= 1'b0;
      skip_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode:     mode_q <= cfg_data_i[1:0];
          RegCapacity: cap_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        pos_q    <= pos_new;
        cnt_q    <= cnt_new;
        trunc_q  <= trunc_new;
        layout_q <= layout_eff;
        skip_q   <= skip_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kept_w   <= keep;
      idx_w    <= idx;
      i_w      <= i_in;
      q_w      <= q_in;
      power_w  <= keep ? power : 16'd0;
      cnt_w    <= cnt_new;
      trunc_w  <= trunc_new;
      layout_w <= layout_eff;
      last_w   <= last;
      x_q      <= keep ? {power, 16'd0} : 32'd0;
      rem_q    <= '0;
      root_q   <= '0;
      step_q   <= '0;
    end else if (cmd_i.step) begin
      x_q    <= {x_q[29:0], 2'b00};
      rem_q  <= fits ? rem_sub[15:0] : rem_next[15:0];
      root_q <= {root_q[RootW-2:0], fits};
      step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {2'b00, cnt_w, root_q, power_w, q_w, i_w, idx_w};
      out_user_o <= {layout_w, trunc_w, kept_w};
      out_last_o <= last_w;
    end
  end

endmodule

`default_nettype wire

### rtl/csi_subcarrier_extractor.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel-state subcarrier extractor. Each input beat is one (q,i) byte pair of an HT20
// channel-state buffer; the beat with start_req set opens a packet and carries its length
// and first-word-invalid flag. Only 256-byte packets are parsed: their 128 pairs map to
// subcarrier indexes 0..31, -32..-1, 0..31, -32..-1. A pair with a nonzero index inside
// the limit of the selected mode is kept until the capacity register is reached, after
// which the truncated flag is raised. Every pair yields exactly one output beat; a kept
// pair reports power i*i+q*q and amplitude sqrt(power) in unsigned Q8.8, rounded down,
// while a dropped pair reports zero for both. The block handles one pair at a time: a
// kept pair is accepted, runs the bit-per-cycle square root loop and loads the output
// register; a dropped pair skips the loop. The output register decouples the sink, so
// the next pair is accepted while a finished beat still waits. The user must write the
// configuration (cfg_we_i / cfg_idx_i / cfg_data_i) only while idle; the block does not
// enforce this. Index 0 is valid_limit_mode (0: 26, 1: 28, 2 or 3: 57), 1 is capacity.
module csi_subcarrier_extractor (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // packet_length [15:0], q_byte [23:16], i_byte [31:24]
  input  wire  [31:0] s_axis_tdata,
  // start_req [0], head_invalid [1]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // subcarrier_index [5:0], i_out [13:6], q_out [21:14], power [37:22],
  // amplitude [53:38], kept_count [61:54], zero [63:62]
  output logic [63:0] m_axis_tdata,
  // kept [0], truncated [1], layout_ok [2]
  output logic [2:0]  m_axis_tuser,
  // last_pair
  output logic        m_axis_tlast,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [7:0]  cfg_data_i
);
  import cse_pkg::*;

  cse_cmd_t    cmd;
  cse_status_t status;

  // The controller sequences accept, square root and output load.
  cse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // The datapath holds the packet state, the pair in flight and the output register.
  cse_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

`ifndef SYNTHESIS
  // The square root never iterates while a new beat can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.step |-> !s_axis_tready)
    else $error("square root step while input is ready");

  // A pending output beat is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");

  // Only one pair is in flight: accepting a beat closes the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while a pair is in flight");

  // A dropped pair carries zero power and amplitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[53:22] == 32'd0))
    else $error("dropped pair with nonzero power or amplitude");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import cse_pkg::*;

  // Per-phase idling profiles for the two stream sides.
  localparam int IdleNone     = 0;
  localparam int IdleSender   = 1;
  localparam int IdleReceiver = 2;
  localparam int IdleBoth     = 3;

  // Cycles to let the block settle before a register write and at the end of the run.
  localparam int SettleCycles = 40;
  // Cycles without any accepted beat on either side before the run is declared hung.
  localparam int StallLimit   = 5000;
  // Random input beats per configuration phase.
  localparam int PhaseBeats   = 195;

  // One (q,i) byte pair as it travels on the input stream.
  typedef struct packed {
    logic        start;
    logic [15:0] len;
    logic        fwi;
    logic [7:0]  q;
    logic [7:0]  i;
  } csi_pair_t;

  // One result beat, split into its fields.
  typedef struct packed {
    logic       kept;
    logic [5:0] idx;
    logic [7:0] i_out;
    logic [7:0] q_out;
    logic [15:0] power;
    logic [15:0] amp;
    logic [7:0] count;
    logic       trunc;
    logic       layout;
    logic       last;
  } csi_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = RegMode;
  logic [7:0]  cfg_data_i = '0;

  csi_subcarrier_extractor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Pairs waiting to be driven, and the beats predicted for accepted pairs, oldest first.
  csi_pair_t pairs_to_send[$];
  csi_beat_t predicted_beats[$];

  int beats_left = 0;       // queued pairs not yet accepted by the block
  int phase_beats = 0;      // pairs queued in the current phase
  int errors = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  logic in_fire = 1'b0;     // an input beat was accepted at the last rising edge

  // Shadow of the block's registers and parsing state.
  logic [1:0] cfg_mode = ModeReset;
  logic [7:0] cfg_cap = CapReset;
  logic [7:0] at_pos = '0;
  logic [7:0] kept_so_far = '0;
  logic       dropped_for_room = 1'b0;
  logic       layout_good = 1'b0;
  logic       skip_head = 1'b0;

  // Floor of the square root, found one result bit at a time from the top.
  function automatic logic [15:0] q88_sqrt(input logic [31:0] x);
    logic [15:0] root;
    logic [15:0] trial;
    longint unsigned sq;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      sq = longint'(trial) * longint'(trial);
      if (sq <= longint'(x)) root = trial;
    end
    return root;
  endfunction

  // Advances the shadow parsing state by one pair and returns the beat it should produce.
  function automatic csi_beat_t parse_pair(input csi_pair_t p);
    csi_beat_t r;
    int iv, qv, sidx, mag, bound, pw;
    iv = int'($signed(p.i));
    qv = int'($signed(p.q));
    if (p.start) begin
      at_pos = '0;
      kept_so_far = '0;
      dropped_for_room = 1'b0;
      layout_good = (p.len == SupportedLen);
      skip_head = p.fwi;
    end
    r = '0;
    r.i_out = p.i;
    r.q_out = p.q;
    // Past the end of the packet the pair is ignored: index 0, no last flag.
    if (at_pos < PairsPerPacket) begin
      // The four 32-pair runs alternate between 0..31 and -32..-1, which is
      // exactly the low six bits of the position read as a signed number.
      r.idx = at_pos[5:0];
      r.last = (at_pos == PairsPerPacket - 8'd1);
      sidx = int'($signed(r.idx));
      mag = (sidx < 0) ? -sidx : sidx;
      case (cfg_mode)
        2'd0: bound = int'(Limit26);
        2'd1: bound = int'(Limit28);
        default: bound = int'(Limit57);
      endcase
      if (layout_good && !(skip_head && at_pos < 8'd2) && mag != 0 && mag <= bound) begin
        if (kept_so_far >= cfg_cap) begin
          dropped_for_room = 1'b1;
        end else begin
          kept_so_far = kept_so_far + 8'd1;
          pw = iv * iv + qv * qv;
          r.kept = 1'b1;
          r.power = pw[15:0];
          r.amp = q88_sqrt(pw << 16);
        end
      end
      at_pos = at_pos + 8'd1;
    end
    r.count = kept_so_far;
    r.trunc = dropped_for_room;
    r.layout = layout_good;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Input side: a new pair goes out at the falling edge once the previous one has been
  // taken, unless the sender chooses to idle this cycle. The receiver's ready is redrawn
  // every cycle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          csi_pair_t nxt;
          nxt = pairs_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nxt.i, nxt.q, nxt.len};
          s_axis_tuser <= {nxt.fwi, nxt.start};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both handshakes are observed at the rising edge: accepted pairs feed the shadow
  // parser, and each result beat is checked against the oldest prediction. The same
  // block runs the hang watchdog.
  always @(posedge clk_i) begin
    csi_pair_t seen;
    csi_beat_t want;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        seen.start = s_axis_tuser[0];
        seen.fwi = s_axis_tuser[1];
        seen.len = s_axis_tdata[15:0];
        seen.q = s_axis_tdata[23:16];
        seen.i = s_axis_tdata[31:24];
        predicted_beats.push_back(parse_pair(seen));
        beats_left--;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_beats.size() == 0) begin
          $error("result beat with no pair waiting for it");
          errors++;
        end else begin
          want = predicted_beats.pop_front();
          check_field("subcarrier_index", longint'($signed(want.idx)),
                      longint'($signed(m_axis_tdata[5:0])));
          check_field("i_out", longint'($signed(want.i_out)),
                      longint'($signed(m_axis_tdata[13:6])));
          check_field("q_out", longint'($signed(want.q_out)),
                      longint'($signed(m_axis_tdata[21:14])));
          check_field("power", longint'(want.power), longint'(m_axis_tdata[37:22]));
          check_field("amplitude", longint'(want.amp), longint'(m_axis_tdata[53:38]));
          check_field("kept_count", longint'(want.count), longint'(m_axis_tdata[61:54]));
          check_field("tdata padding", longint'(0), longint'(m_axis_tdata[63:62]));
          check_field("kept", longint'(want.kept), longint'(m_axis_tuser[0]));
          check_field("truncated", longint'(want.trunc), longint'(m_axis_tuser[1]));
          check_field("layout_ok", longint'(want.layout), longint'(m_axis_tuser[2]));
          check_field("last_pair", longint'(want.last), longint'(m_axis_tlast));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic queue_pair(input logic start, input logic [15:0] len, input logic fwi,
                            input logic [7:0] q, input logic [7:0] i);
    csi_pair_t p;
    p.start = start;
    p.len = len;
    p.fwi = fwi;
    p.q = q;
    p.i = i;
    pairs_to_send.push_back(p);
    beats_left++;
    phase_beats++;
  endtask

  // The corner byte values: most negative, most positive, zero and minus one.
  function automatic logic [7:0] corner_byte(input int sel);
    case (sel % 4)
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  // Mostly random bytes, with the corners showing up often enough to matter.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(7) == 0) return corner_byte($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // One packet. Most are well-formed 256-byte packets, some of them followed by stray
  // pairs past the 128th; the rest are cut short by the next start or carry a length
  // that the block does not parse.
  task automatic queue_packet();
    int kind, n;
    logic [15:0] len;
    logic fwi;
    kind = $urandom_range(99);
    fwi = ($urandom_range(2) == 0);
    if (kind < 70) begin
      len = SupportedLen;
      n = 128 + (($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0);
    end else if (kind < 85) begin
      len = SupportedLen;
      n = $urandom_range(1, 127);
    end else begin
      len = 16'($urandom_range(16'hFFFF));
      n = $urandom_range(1, 140);
    end
    queue_pair(1'b1, len, fwi, pick_byte(), pick_byte());
    // Length and flag bits on later pairs are don't-care, so they are random too.
    for (int k = 1; k < n; k++) begin
      queue_pair(1'b0, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                 pick_byte(), pick_byte());
    end
  endtask

  // Waits until every queued pair has been taken and every predicted beat has come back,
  // then gives the block a few more cycles to go quiet.
  task automatic drain_and_settle();
    do @(negedge clk_i); while (beats_left != 0 || predicted_beats.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One configuration phase: registers are changed only once the block is idle, then a
  // batch of random packets runs under the given idling profile.
  task automatic run_phase(input logic [1:0] mode, input logic [7:0] cap, input int idling);
    drain_and_settle();
    write_reg(RegMode, {6'd0, mode});
    write_reg(RegCapacity, cap);
    cfg_mode = mode;
    cfg_cap = cap;
    send_gap_pct = (idling == IdleSender) ? 46 : (idling == IdleBoth) ? 36 : 0;
    recv_stall_pct = (idling == IdleReceiver) ? 46 : (idling == IdleBoth) ? 36 : 0;
    phase_beats = 0;
    while (phase_beats < PhaseBeats) queue_packet();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset configuration. Pairs before any start must never be
    // kept, whatever their length and flag bits say.
    queue_pair(1'b0, 16'hFFFF, 1'b1, 8'h80, 8'h80);
    queue_pair(1'b0, 16'h0000, 1'b0, 8'h7F, 8'h7F);
    queue_pair(1'b0, 16'h5AA5, 1'b1, 8'h00, 8'hFF);
    // A packet one byte short of the supported layout: nothing kept, positions still count.
    queue_pair(1'b1, SupportedLen - 16'd1, 1'b0, 8'h7F, 8'h80);
    queue_pair(1'b0, 16'h0000, 1'b0, 8'h80, 8'h7F);
    // A supported packet with its first word marked invalid. The first two pairs are
    // dropped, the rest walk through every pairing of corner values, including the
    // full-scale pair whose power is 32768.
    queue_pair(1'b1, SupportedLen, 1'b1, 8'h80, 8'h80);
    for (int k = 1; k < 18; k++) begin
      queue_pair(1'b0, 16'hFFFF, k[0], corner_byte(k), corner_byte(k / 4));
    end

    // Random phases across all limit modes (the undefined one too) and the capacity
    // extremes, with every idling profile.
    run_phase(2'd0, 8'd0, IdleNone);
    run_phase(2'd2, 8'd128, IdleSender);
    run_phase(2'd3, 8'd255, IdleReceiver);
    run_phase(2'd1, 8'd5, IdleBoth);
    run_phase(2'd0, 8'd40, IdleSender);
    run_phase(2'd2, 8'd1, IdleBoth);
    run_phase(2'd1, 8'($urandom_range(2, 127)), IdleReceiver);

    drain_and_settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
